[design/plist_pkg.sv]
// types and constants shared by the positional record list
// no dependencies
`default_nettype none

package plist_pkg;

   // widths sized for the largest supported list (256 entries)
   localparam int CNT_MAX_W = 9;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SWAP   = 2'd2,
      CMD_VIEW   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_INVALID = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_EMPTY   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_SWAP,
      CELL_ROTATE
   } cell_mode_type;

   typedef enum logic {
      ST_IDLE,
      ST_VIEW
   } state_type;

   typedef struct packed {
      logic [15:0]        year;
      logic signed [31:0] revenue;
   } rec_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [7:0]         pos_a;
      logic [7:0]         pos_b;
      logic [15:0]        new_year;
      logic signed [31:0] new_revenue;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [4:0]         out_position;
      logic [15:0]        out_year;
      logic signed [31:0] out_revenue;
      logic [4:0]         entry_total;
      logic               last;
   } rsp_type;

   // broadcast to every cell; positions are zero-based here
   typedef struct packed {
      cell_mode_type          mode;
      logic [CNT_MAX_W-1:0]   pos_a;
      logic [CNT_MAX_W-1:0]   pos_b;
      logic [CNT_MAX_W-1:0]   count;
      rec_type                new_rec;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[design/plist_cell.sv]
// one storage cell of the positional record list: holds a record and
// takes a neighbor's, the new or a swapped record as the command says
// depends on plist_pkg
`default_nettype none

module plist_cell #(
   parameter int INDEX = 0
) (
   input  wire                          clock,
   input  wire plist_pkg::cell_ctrl_type ctrl,
   input  wire plist_pkg::rec_type      left_rec,
   input  wire plist_pkg::rec_type      right_rec,
   input  wire plist_pkg::rec_type      head_rec,
   input  wire plist_pkg::rec_type      swap_a_rec,
   input  wire plist_pkg::rec_type      swap_b_rec,
   output plist_pkg::rec_type           rec
);
   import plist_pkg::*;

   localparam logic [CNT_MAX_W-1:0] MY_IDX  = CNT_MAX_W'(INDEX);
   localparam logic [CNT_MAX_W-1:0] MY_NEXT = CNT_MAX_W'(INDEX + 1);

   rec_type rec_ff, rec_in;

   always_comb begin
      rec_in = rec_ff;
      case (ctrl.mode)
         CELL_INSERT: begin
            if (MY_IDX == ctrl.pos_a) begin
               rec_in = ctrl.new_rec;
            end else if (MY_IDX > ctrl.pos_a && MY_IDX <= ctrl.count) begin
               rec_in = left_rec;
            end
         end
         CELL_DELETE: begin
            if (MY_IDX >= ctrl.pos_a && MY_NEXT < ctrl.count) begin
               rec_in = right_rec;
            end
         end
         CELL_SWAP: begin
            if (MY_IDX == ctrl.pos_a) begin
               rec_in = swap_b_rec;
            end else if (MY_IDX == ctrl.pos_b) begin
               rec_in = swap_a_rec;
            end
         end
         CELL_ROTATE: begin
            // head record wraps around to the tail of the held entries
            if (MY_NEXT < ctrl.count) begin
               rec_in = right_rec;
            end else if (MY_NEXT == ctrl.count) begin
               rec_in = head_rec;
            end
         end
         default: begin
            rec_in = rec_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;

endmodule

`default_nettype wire

[design/positional_record_list.sv]
// positional record list top level: control, status and the row of cells
// depends on plist_pkg and plist_cell
`default_nettype none

// Ordered list of up to DEPTH records (year, signed revenue) held in a row
// of cells, one record per cell. A request is taken when start is high and
// busy is low. Insert and delete shift records between neighboring cells,
// and swap exchanges two records, in the cycle the request is taken; their
// single response shows on rsp in the next cycle, and busy stays low, so
// one such request per cycle is accepted. View rotates the row by one cell
// per cycle and sends the head record out each cycle, keeping busy high
// until the last entry is sent out, and gives one response per entry (one
// empty response when the list is empty). Responses stand on rsp for
// exactly one cycle, marked by rsp_strobe; the receiver cannot stall them.

module positional_record_list #(
   parameter int DEPTH = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  wire plist_pkg::req_type req,
   output logic                   rsp_strobe,
   output plist_pkg::rsp_type     rsp
);
   import plist_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     view_pos_ff, view_pos_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   cell_ctrl_type        ctrl;
   rec_type              cell_rec [DEPTH];
   rec_type              swap_a_rec, swap_b_rec;

   logic                 accept;
   logic [CNT_MAX_W-1:0] pa, pb, cnt_wide;
   logic                 ins_ok, ins_full, del_ok, swp_ok, at_end;

   assign busy     = (state_ff == ST_VIEW);
   assign accept   = start && !busy;
   assign pa       = CNT_MAX_W'(req.pos_a);
   assign pb       = CNT_MAX_W'(req.pos_b);
   assign cnt_wide = CNT_MAX_W'(count_ff);

   assign ins_ok   = (pa != '0) && ((pa - 1'b1) <= cnt_wide);
   assign ins_full = (count_ff == CNT_W'(DEPTH));
   assign del_ok   = (pa != '0) && (pa <= cnt_wide);
   assign swp_ok   = del_ok && (pb != '0) && (pb <= cnt_wide);
   assign at_end   = (view_pos_ff == count_ff);

   // records at the two swap positions
   always_comb begin
      swap_a_rec = cell_rec[0];
      swap_b_rec = cell_rec[0];
      for (int i = 0; i < DEPTH; i++) begin
         if (CNT_MAX_W'(i) == ctrl.pos_a) begin
            swap_a_rec = cell_rec[i];
         end
         if (CNT_MAX_W'(i) == ctrl.pos_b) begin
            swap_b_rec = cell_rec[i];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req.cmd == CMD_VIEW && count_ff != '0) begin
               state_in = ST_VIEW;
            end
         end
         ST_VIEW: begin
            if (at_end) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // cell control, count and response
   always_comb begin
      ctrl.mode    = CELL_HOLD;
      ctrl.pos_a   = pa - 1'b1;
      ctrl.pos_b   = pb - 1'b1;
      ctrl.count   = cnt_wide;
      ctrl.new_rec = '{year: req.new_year, revenue: req.new_revenue};
      count_in      = count_ff;
      view_pos_in   = view_pos_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               rsp_in.last   = 1'b1;
               rsp_in.status = STAT_OK;
               case (req.cmd)
                  CMD_INSERT: begin
                     if (!ins_ok) begin
                        rsp_in.status = STAT_INVALID;
                     end else if (ins_full) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        ctrl.mode = CELL_INSERT;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  CMD_DELETE: begin
                     if (!del_ok) begin
                        rsp_in.status = STAT_INVALID;
                     end else begin
                        ctrl.mode = CELL_DELETE;
                        count_in  = count_ff - 1'b1;
                     end
                  end
                  CMD_SWAP: begin
                     if (!swp_ok) begin
                        rsp_in.status = STAT_INVALID;
                     end else begin
                        ctrl.mode = CELL_SWAP;
                     end
                  end
                  CMD_VIEW: begin
                     if (count_ff == '0) begin
                        rsp_in.status = STAT_EMPTY;
                     end else begin
                        rsp_strobe_in = 1'b0;
                        view_pos_in   = CNT_W'(1);
                     end
                  end
                  default: begin
                     rsp_in.status = STAT_INVALID;
                  end
               endcase
               rsp_in.entry_total = 5'(count_in);
            end
         end
         ST_VIEW: begin
            ctrl.mode           = CELL_ROTATE;
            rsp_strobe_in       = 1'b1;
            rsp_in.status       = STAT_OK;
            rsp_in.out_position = 5'(view_pos_ff);
            rsp_in.out_year     = cell_rec[0].year;
            rsp_in.out_revenue  = cell_rec[0].revenue;
            rsp_in.entry_total  = 5'(count_ff);
            rsp_in.last         = at_end;
            view_pos_in         = view_pos_ff + 1'b1;
         end
         default: begin
            ctrl.mode = CELL_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         view_pos_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         view_pos_ff   <= view_pos_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      plist_cell #(
         .INDEX(g)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .left_rec   (cell_rec[(g == 0) ? 0 : g - 1]),
         .right_rec  (cell_rec[(g == DEPTH - 1) ? g : g + 1]),
         .head_rec   (cell_rec[0]),
         .swap_a_rec (swap_a_rec),
         .swap_b_rec (swap_b_rec),
         .rec        (cell_rec[g])
      );
   end

   // the final view step closes the command with a last response
   a_view_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VIEW && at_end) |=> (rsp_strobe && rsp.last && !busy))
      else $error("view did not end with a last response");

   // list never grows past its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   // an edit request always answers in the next cycle
   a_edit_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req.cmd != CMD_VIEW) |=> (rsp_strobe && rsp.last))
      else $error("edit request without a response");

   // the count holds while the row rotates
   a_view_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VIEW) |=> $stable(count_ff))
      else $error("entry count changed during view");

endmodule

`default_nettype wire
